[design/u8wc_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 decode and width classifier package
// Shared types, constants and scalar classification functions.
// ----------------------------------------------------------------------------
package u8wc_pkg;

    localparam int unsigned SCALAR_W = 21;
    localparam int unsigned MAX_RES  = 4;

    localparam logic [SCALAR_W-1:0] MAX_SCALAR = 21'h10ffff;
    localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h00d800;
    localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h00dfff;
    localparam logic [SCALAR_W-1:0] MIN_LEN2   = 21'h000080;
    localparam logic [SCALAR_W-1:0] MIN_LEN3   = 21'h000800;
    localparam logic [SCALAR_W-1:0] MIN_LEN4   = 21'h010000;

    localparam logic [1:0] WIDTH_ZERO   = 2'd0;
    localparam logic [1:0] WIDTH_NARROW = 2'd1;
    localparam logic [1:0] WIDTH_WIDE   = 2'd2;

    localparam int unsigned ZW_NUM = 30;

    localparam logic [15:0] ZW_LO [ZW_NUM] = '{
        16'h0300, 16'h0483, 16'h0591, 16'h05bf, 16'h05c1, 16'h05c4,
        16'h05c7, 16'h0610, 16'h064b, 16'h0670, 16'h06d6, 16'h06df,
        16'h06e7, 16'h06ea, 16'h0711, 16'h0730, 16'h07a6, 16'h07eb,
        16'h0901, 16'h093c, 16'h0941, 16'h094d, 16'h0951, 16'h0962,
        16'h0e31, 16'h0e34, 16'h0e47, 16'h1dc0, 16'h20d0, 16'hfe20
    };

    localparam logic [15:0] ZW_HI [ZW_NUM] = '{
        16'h036f, 16'h0489, 16'h05bd, 16'h05bf, 16'h05c2, 16'h05c5,
        16'h05c7, 16'h061a, 16'h065f, 16'h0670, 16'h06dc, 16'h06e4,
        16'h06e8, 16'h06ed, 16'h0711, 16'h074a, 16'h07b0, 16'h07f3,
        16'h0902, 16'h093c, 16'h0948, 16'h094d, 16'h0954, 16'h0963,
        16'h0e31, 16'h0e3a, 16'h0e4e, 16'h1dff, 16'h20f0, 16'hfe23
    };

    typedef struct packed {
        logic [SCALAR_W-1:0] acc;
        logic [2:0]          exp_len;
        logic [2:0]          coll;
    } dec_state_t;

    typedef struct packed {
        logic [SCALAR_W-1:0] val;
        logic [2:0]          cnt;
        logic                ok;
    } res_ent_t;

    typedef struct packed {
        logic [2:0]             num;
        res_ent_t [MAX_RES-1:0] ent;
    } res_list_t;

    function automatic res_list_t push_res(input res_list_t lst,
                                           input logic [SCALAR_W-1:0] val,
                                           input logic [2:0] cnt,
                                           input logic ok);
        res_list_t r;
        r = lst;
        r.ent[lst.num[1:0]].val = val;
        r.ent[lst.num[1:0]].cnt = cnt;
        r.ent[lst.num[1:0]].ok  = ok;
        r.num = lst.num + 3'd1;
        return r;
    endfunction

    function automatic logic in_rng(input logic [SCALAR_W-1:0] v,
                                    input logic [SCALAR_W-1:0] lo,
                                    input logic [SCALAR_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic is_ctrl(input logic [SCALAR_W-1:0] v);
        return ((v != '0) && (v < 21'h20)) || in_rng(v, 21'h7f, 21'h9f);
    endfunction

    function automatic logic is_unsafe(input logic [SCALAR_W-1:0] v);
        return (v < 21'h20) || in_rng(v, 21'h7f, 21'h9f) ||
               in_rng(v, 21'h2028, 21'h2029) || in_rng(v, 21'h200b, 21'h200f) ||
               in_rng(v, 21'h202a, 21'h202e) || in_rng(v, 21'h2066, 21'h2069) ||
               (v == 21'hfeff) || in_rng(v, 21'hfff9, 21'hfffb);
    endfunction

    function automatic logic [1:0] disp_width(input logic [SCALAR_W-1:0] v);
        logic zw;
        logic wide;
        zw = (v == '0) || is_ctrl(v);
        for (int i = 0; i < ZW_NUM; i++) begin
            if (in_rng(v, {5'd0, ZW_LO[i]}, {5'd0, ZW_HI[i]})) begin
                zw = 1'b1;
            end
        end
        wide = in_rng(v, 21'h1100, 21'h115f) || (v == 21'h2329) || (v == 21'h232a) ||
               (in_rng(v, 21'h2e80, 21'ha4cf) && (v != 21'h303f)) ||
               in_rng(v, 21'hac00, 21'hd7a3) || in_rng(v, 21'hf900, 21'hfaff) ||
               in_rng(v, 21'hfe10, 21'hfe19) || in_rng(v, 21'hfe30, 21'hfe6f) ||
               in_rng(v, 21'hff00, 21'hff60) || in_rng(v, 21'hffe0, 21'hffe6) ||
               in_rng(v, 21'h20000, 21'h2fffd) || in_rng(v, 21'h30000, 21'h3fffd);
        if (zw) begin
            return WIDTH_ZERO;
        end
        if (wide) begin
            return WIDTH_WIDE;
        end
        return WIDTH_NARROW;
    endfunction

endpackage

[design/u8wc_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 byte decoder
// Steps the sequence state by one byte and lists the results it causes.
// ----------------------------------------------------------------------------
module u8wc_decode (
    input  logic [7:0]            data_byte,
    input  logic                  end_of_stream,
    input  u8wc_pkg::dec_state_t  st,
    input  logic [2:0][7:0]       pend,
    output u8wc_pkg::dec_state_t  st_next,
    output logic [2:0][7:0]       pend_next,
    output u8wc_pkg::res_list_t   res
);

    u8wc_pkg::dec_state_t              w;
    u8wc_pkg::res_list_t               lst;
    logic [2:0][7:0]                   pn;
    logic                              taken;
    logic                              cont;
    logic                              done;
    logic                              bad;
    logic [u8wc_pkg::SCALAR_W-1:0]     acc_ext;
    logic [u8wc_pkg::SCALAR_W-1:0]     minv;

    always_comb begin
        case (st.exp_len)
            3'd2:    minv = u8wc_pkg::MIN_LEN2;
            3'd3:    minv = u8wc_pkg::MIN_LEN3;
            default: minv = u8wc_pkg::MIN_LEN4;
        endcase
    end

    assign cont    = (data_byte[7:6] == 2'b10);
    assign acc_ext = {st.acc[14:0], data_byte[5:0]};
    assign done    = (({1'b0, st.coll} + 4'd1) >= {1'b0, st.exp_len});
    assign bad     = (acc_ext < minv) || (acc_ext > u8wc_pkg::MAX_SCALAR) ||
                     u8wc_pkg::in_rng(acc_ext, u8wc_pkg::SURR_LO, u8wc_pkg::SURR_HI);

    always_comb begin
        w     = st;
        pn    = pend;
        lst   = '0;
        taken = 1'b0;

        if (st.exp_len != 3'd0) begin
            if (cont) begin
                taken = 1'b1;
                if (done) begin
                    if (bad) begin
                        for (int i = 0; i < 3; i++) begin
                            if (3'(i) < st.coll) begin
                                lst = u8wc_pkg::push_res(lst, {13'd0, pend[i]}, 3'd1, 1'b0);
                            end
                        end
                        lst = u8wc_pkg::push_res(lst, {13'd0, data_byte}, 3'd1, 1'b0);
                    end else begin
                        lst = u8wc_pkg::push_res(lst, acc_ext, st.exp_len, 1'b1);
                    end
                    w = '0;
                end else begin
                    w.acc = acc_ext;
                    if (st.coll < 3'd3) begin
                        pn[st.coll[1:0]] = data_byte;
                    end
                    w.coll = st.coll + 3'd1;
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (3'(i) < st.coll) begin
                        lst = u8wc_pkg::push_res(lst, {13'd0, pend[i]}, 3'd1, 1'b0);
                    end
                end
                w = '0;
            end
        end

        if (!taken) begin
            if (!data_byte[7]) begin
                lst = u8wc_pkg::push_res(lst, {13'd0, data_byte}, 3'd1, 1'b1);
            end else if (data_byte[7:5] == 3'b110) begin
                w.exp_len = 3'd2;
                w.acc     = {16'd0, data_byte[4:0]};
                w.coll    = 3'd1;
                pn[0]     = data_byte;
            end else if (data_byte[7:4] == 4'b1110) begin
                w.exp_len = 3'd3;
                w.acc     = {17'd0, data_byte[3:0]};
                w.coll    = 3'd1;
                pn[0]     = data_byte;
            end else if (data_byte[7:3] == 5'b11110) begin
                w.exp_len = 3'd4;
                w.acc     = {18'd0, data_byte[2:0]};
                w.coll    = 3'd1;
                pn[0]     = data_byte;
            end else begin
                lst = u8wc_pkg::push_res(lst, {13'd0, data_byte}, 3'd1, 1'b0);
            end
        end

        if (end_of_stream) begin
            for (int i = 0; i < 3; i++) begin
                if (3'(i) < w.coll) begin
                    lst = u8wc_pkg::push_res(lst, {13'd0, pn[i]}, 3'd1, 1'b0);
                end
            end
            w = '0;
        end

        st_next   = w;
        pend_next = pn;
        res       = lst;
    end

endmodule

[design/utf8_decode_width_classifier_top.sv]
// ----------------------------------------------------------------------------
// UTF-8 decode and width classifier, top level
// Path: accepted byte -> result list register -> output register (m_valid).
// Throughput: one byte per cycle while each byte gives at most one result and
// the output is not stalled; a byte giving several results holds the input
// until its last pops (one result per cycle from the result list, unless stalled).
// Reset: synchronous, active low; clears the sequence state, list and output valid.
// ----------------------------------------------------------------------------
module utf8_decode_width_classifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_scalar_value,
    output logic [2:0]  m_byte_count,
    output logic        m_is_valid,
    output logic        m_is_control,
    output logic [1:0]  m_display_width,
    output logic        m_is_unsafe,
    output logic        m_last_result
);

    u8wc_pkg::dec_state_t st_reg;
    u8wc_pkg::dec_state_t st_next;
    logic [2:0][7:0]      pend_reg;
    logic [2:0][7:0]      pend_next;
    u8wc_pkg::res_list_t  lst_reg;
    u8wc_pkg::res_list_t  lst_next;
    logic [1:0]           head_reg;
    u8wc_pkg::res_ent_t   cur;
    logic                 accept;
    logic                 pop;
    logic                 is_last;

    logic                 m_valid_reg;
    logic [20:0]          val_reg;
    logic [2:0]           cnt_reg;
    logic                 ok_reg;
    logic                 ctrl_reg;
    logic [1:0]           width_reg;
    logic                 unsafe_reg;
    logic                 last_reg;

    u8wc_decode u_dec (
        .data_byte     (s_data_byte),
        .end_of_stream (s_end_of_stream),
        .st            (st_reg),
        .pend          (pend_reg),
        .st_next       (st_next),
        .pend_next     (pend_next),
        .res           (lst_next)
    );

    assign cur     = lst_reg.ent[head_reg];
    assign is_last = (({1'b0, head_reg} + 3'd1) == lst_reg.num);
    assign pop     = (lst_reg.num != 3'd0) && (!m_valid_reg || m_ready);
    assign s_ready = (lst_reg.num == 3'd0) || (pop && is_last);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            lst_reg     <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_reg   <= st_next;
                lst_reg  <= lst_next;
                head_reg <= '0;
            end else if (pop && is_last) begin
                lst_reg.num <= '0;
                head_reg    <= '0;
            end else if (pop) begin
                head_reg <= head_reg + 2'd1;
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // held bytes: only read where written
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            val_reg    <= cur.val;
            cnt_reg    <= cur.cnt;
            ok_reg     <= cur.ok;
            ctrl_reg   <= cur.ok && u8wc_pkg::is_ctrl(cur.val);
            width_reg  <= cur.ok ? u8wc_pkg::disp_width(cur.val) : u8wc_pkg::WIDTH_ZERO;
            unsafe_reg <= cur.ok && u8wc_pkg::is_unsafe(cur.val);
            last_reg   <= is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_scalar_value  = val_reg;
    assign m_byte_count    = cnt_reg;
    assign m_is_valid      = ok_reg;
    assign m_is_control    = ctrl_reg;
    assign m_display_width = width_reg;
    assign m_is_unsafe     = unsafe_reg;
    assign m_last_result   = last_reg;

    a_idle_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.exp_len == 3'd0) |-> (st_reg.coll == 3'd0))
        else $error("held byte count without a pending sequence");

    a_count_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.exp_len != 3'd0) |-> (st_reg.coll != 3'd0) && (st_reg.coll < st_reg.exp_len))
        else $error("held byte count out of range");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_stream) |=> (st_reg.exp_len == 3'd0))
        else $error("sequence still pending after end of stream");

    a_list_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (lst_reg.num <= 3'd4) && ((lst_reg.num == 3'd0) || ({1'b0, head_reg} < lst_reg.num)))
        else $error("result list head beyond its length");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_valid) |->
            (m_byte_count == 3'd1) && (m_display_width == u8wc_pkg::WIDTH_ZERO) &&
            !m_is_control && !m_is_unsafe && (m_scalar_value < 21'h100))
        else $error("error result with scalar attributes");

endmodule

[test/utf8_decode_width_classifier_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 decode and width classifier testbench
// Streams directed and random byte requests into the decoder, predicts every
// decoded scalar or error byte with a local decoder model, and checks each
// result field by field in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module utf8_decode_width_classifier_top_test;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } byte_req_t;

    typedef struct packed {
        logic [20:0] scalar;
        logic [2:0]  count;
        logic        ok;
        logic        ctrl;
        logic [1:0]  cols;
        logic        unsafe;
        logic        last_flag;
    } glyph_t;

    localparam logic [20:0] MARK_FIRST [30] = '{
        21'h0300, 21'h0483, 21'h0591, 21'h05bf, 21'h05c1, 21'h05c4,
        21'h05c7, 21'h0610, 21'h064b, 21'h0670, 21'h06d6, 21'h06df,
        21'h06e7, 21'h06ea, 21'h0711, 21'h0730, 21'h07a6, 21'h07eb,
        21'h0901, 21'h093c, 21'h0941, 21'h094d, 21'h0951, 21'h0962,
        21'h0e31, 21'h0e34, 21'h0e47, 21'h1dc0, 21'h20d0, 21'hfe20
    };
    localparam logic [20:0] MARK_LAST [30] = '{
        21'h036f, 21'h0489, 21'h05bd, 21'h05bf, 21'h05c2, 21'h05c5,
        21'h05c7, 21'h061a, 21'h065f, 21'h0670, 21'h06dc, 21'h06e4,
        21'h06e8, 21'h06ed, 21'h0711, 21'h074a, 21'h07b0, 21'h07f3,
        21'h0902, 21'h093c, 21'h0948, 21'h094d, 21'h0954, 21'h0963,
        21'h0e31, 21'h0e3a, 21'h0e4e, 21'h1dff, 21'h20f0, 21'hfe23
    };
    localparam logic [20:0] EDGE_CP [28] = '{
        21'h00000, 21'h0001f, 21'h00020, 21'h0007f, 21'h0009f, 21'h000a0,
        21'h00300, 21'h0036f, 21'h00370, 21'h200b, 21'h200f, 21'h2028,
        21'h2029, 21'h202a, 21'h202e, 21'h2066, 21'h2069, 21'h2329,
        21'h1100, 21'h115f, 21'h2e80, 21'h303f, 21'ha4cf, 21'hac00,
        21'hd7a3, 21'hfeff, 21'hfff9, 21'hfffb
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [20:0] m_scalar_value;
    logic [2:0]  m_byte_count;
    logic        m_is_valid;
    logic        m_is_control;
    logic [1:0]  m_display_width;
    logic        m_is_unsafe;
    logic        m_last_result;

    byte_req_t byte_q[$];
    glyph_t    glyph_q[$];
    glyph_t    step_q[$];

    logic [20:0] seq_acc = '0;
    logic [2:0]  seq_len = '0;
    logic [2:0]  seq_have = '0;
    logic [7:0]  seq_held [3];

    int queued = 0;
    int sent = 0;
    int got = 0;
    int errors = 0;

    utf8_decode_width_classifier_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scalar_value  (m_scalar_value),
        .m_byte_count    (m_byte_count),
        .m_is_valid      (m_is_valid),
        .m_is_control    (m_is_control),
        .m_display_width (m_display_width),
        .m_is_unsafe     (m_is_unsafe),
        .m_last_result   (m_last_result)
    );

    function automatic logic spans(input logic [20:0] v, input logic [20:0] lo,
                                   input logic [20:0] hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic logic ctrl_cp(input logic [20:0] v);
        return (v != 0 && v < 21'h20) || spans(v, 21'h7f, 21'h9f);
    endfunction

    function automatic logic unsafe_cp(input logic [20:0] v);
        return v < 21'h20 || spans(v, 21'h7f, 21'h9f) || spans(v, 21'h2028, 21'h2029) ||
               spans(v, 21'h200b, 21'h200f) || spans(v, 21'h202a, 21'h202e) ||
               spans(v, 21'h2066, 21'h2069) || v == 21'hfeff ||
               spans(v, 21'hfff9, 21'hfffb);
    endfunction

    function automatic logic [1:0] cols_of(input logic [20:0] v);
        if (v == 0 || ctrl_cp(v)) begin
            return u8wc_pkg::WIDTH_ZERO;
        end
        for (int i = 0; i < 30; i++) begin
            if (spans(v, MARK_FIRST[i], MARK_LAST[i])) begin
                return u8wc_pkg::WIDTH_ZERO;
            end
        end
        if (v >= 21'h1100 && (v <= 21'h115f || v == 21'h2329 || v == 21'h232a ||
            (spans(v, 21'h2e80, 21'ha4cf) && v != 21'h303f) ||
            spans(v, 21'hac00, 21'hd7a3) || spans(v, 21'hf900, 21'hfaff) ||
            spans(v, 21'hfe10, 21'hfe19) || spans(v, 21'hfe30, 21'hfe6f) ||
            spans(v, 21'hff00, 21'hff60) || spans(v, 21'hffe0, 21'hffe6) ||
            spans(v, 21'h20000, 21'h2fffd) || spans(v, 21'h30000, 21'h3fffd))) begin
            return u8wc_pkg::WIDTH_WIDE;
        end
        return u8wc_pkg::WIDTH_NARROW;
    endfunction

    function automatic void emit(input logic [20:0] v, input logic [2:0] n, input logic ok);
        glyph_t g;
        g.scalar    = v;
        g.count     = n;
        g.ok        = ok;
        g.ctrl      = ok && ctrl_cp(v);
        g.cols      = ok ? cols_of(v) : u8wc_pkg::WIDTH_ZERO;
        g.unsafe    = ok && unsafe_cp(v);
        g.last_flag = 1'b0;
        if (step_q.size() < u8wc_pkg::MAX_RES) begin
            step_q.push_back(g);
        end
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < seq_have && i < 3; i++) begin
            emit({13'd0, seq_held[i]}, 3'd1, 1'b0);
        end
        seq_acc  = '0;
        seq_len  = '0;
        seq_have = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        logic [20:0] v;
        logic [20:0] floor_v;
        logic        relead;
        relead = 1'b1;
        step_q.delete();
        if (seq_len != 0) begin
            if (b[7:6] == 2'b10) begin
                relead = 1'b0;
                v = {seq_acc[14:0], b[5:0]};
                if (seq_have + 1 >= seq_len) begin
                    floor_v = seq_len == 2 ? 21'h80 : seq_len == 3 ? 21'h800 : 21'h10000;
                    if (v < floor_v || v > 21'h10ffff || spans(v, 21'hd800, 21'hdfff)) begin
                        flush_held();
                        emit({13'd0, b}, 3'd1, 1'b0);
                    end else begin
                        emit(v, seq_len, 1'b1);
                        seq_acc  = '0;
                        seq_len  = '0;
                        seq_have = '0;
                    end
                end else begin
                    seq_acc = v;
                    if (seq_have < 3) begin
                        seq_held[seq_have] = b;
                    end
                    seq_have = seq_have + 1;
                end
            end else begin
                flush_held();
            end
        end
        if (relead) begin
            if (b < 8'h80) begin
                emit({13'd0, b}, 3'd1, 1'b1);
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
                seq_len     = b[7:5] == 3'b110 ? 3'd2 : b[7:4] == 4'b1110 ? 3'd3 : 3'd4;
                seq_acc     = b[7:5] == 3'b110 ? {16'd0, b[4:0]} :
                              b[7:4] == 4'b1110 ? {17'd0, b[3:0]} : {18'd0, b[2:0]};
                seq_held[0] = b;
                seq_have    = 3'd1;
            end else begin
                emit({13'd0, b}, 3'd1, 1'b0);
            end
        end
        if (eos) begin
            flush_held();
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].last_flag = 1'b1;
        end
        foreach (step_q[i]) begin
            glyph_q.push_back(step_q[i]);
        end
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic eos);
        byte_req_t r;
        r.data = b;
        r.eos  = eos;
        byte_q.push_back(r);
        queued++;
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic add_scalar(input logic [20:0] v, input logic eos);
        if (v < 21'h80) begin
            add_byte(v[7:0], eos);
        end else if (v < 21'h800) begin
            add_byte({3'b110, v[10:6]}, 1'b0);
            add_byte({2'b10, v[5:0]}, eos);
        end else if (v < 21'h10000) begin
            add_byte({4'b1110, v[15:12]}, 1'b0);
            add_byte({2'b10, v[11:6]}, 1'b0);
            add_byte({2'b10, v[5:0]}, eos);
        end else begin
            add_byte({5'b11110, v[20:18]}, 1'b0);
            add_byte({2'b10, v[17:12]}, 1'b0);
            add_byte({2'b10, v[11:6]}, 1'b0);
            add_byte({2'b10, v[5:0]}, eos);
        end
    endtask

    task automatic add_valid();
        logic [20:0] v;
        case ($urandom_range(5))
            0: v = 21'($urandom_range(8'h7f));
            1: v = 21'($urandom_range(11'h7ff, 8'h80));
            2: v = 21'($urandom_range(16'hffff, 12'h800));
            3: v = 21'($urandom_range(21'h10ffff, 21'h10000));
            4: v = 21'($urandom_range(21'h3fffd, 21'h20000));
            default: v = EDGE_CP[$urandom_range(27)];
        endcase
        if (spans(v, 21'hd800, 21'hdfff)) begin
            v = v ^ 21'h1000;
        end
        add_scalar(v, $urandom_range(99) < 6);
    endtask

    // malformed, truncated and broken sequences plus raw noise
    task automatic add_noise();
        logic [7:0] seq[$];
        int         len;
        logic       eos;
        eos = $urandom_range(99) < 10;
        case ($urandom_range(6))
            0: seq.push_back(8'($urandom));
            1: seq.push_back($urandom_range(1) ? 8'($urandom_range(8'hbf, 8'h80))
                                               : 8'($urandom_range(8'hff, 8'hf8)));
            2: begin
                len = $urandom_range(4, 2);
                seq.push_back(len == 2 ? {3'b110, 5'($urandom)} :
                              len == 3 ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)});
                repeat ($urandom_range(len - 2)) seq.push_back(cont_byte());
                eos = $urandom_range(1);
            end
            3: begin
                case ($urandom_range(2))
                    0: seq.push_back(8'($urandom_range(8'hc1, 8'hc0)));
                    1: begin
                        seq.push_back(8'he0);
                        seq.push_back(8'($urandom_range(8'h9f, 8'h80)));
                    end
                    default: begin
                        seq.push_back(8'hf0);
                        seq.push_back(8'($urandom_range(8'h8f, 8'h80)));
                        seq.push_back(cont_byte());
                    end
                endcase
                seq.push_back(cont_byte());
            end
            4: begin
                seq.push_back(8'hed);
                seq.push_back(8'($urandom_range(8'hbf, 8'ha0)));
                seq.push_back(cont_byte());
            end
            5: begin
                if ($urandom_range(1)) begin
                    seq.push_back(8'hf4);
                    seq.push_back(8'($urandom_range(8'hbf, 8'h90)));
                end else begin
                    seq.push_back(8'($urandom_range(8'hf7, 8'hf5)));
                    seq.push_back(cont_byte());
                end
                seq.push_back(cont_byte());
                seq.push_back(cont_byte());
            end
            default: begin
                len = $urandom_range(4, 2);
                seq.push_back(len == 2 ? 8'hc3 : len == 3 ? 8'he3 : 8'hf0);
                if (len == 4) begin
                    seq.push_back(8'h9f);
                end
                repeat ($urandom_range(len - 2)) seq.push_back(cont_byte());
                seq.push_back($urandom_range(1) ? 8'($urandom_range(8'h7f))
                                                : 8'($urandom_range(8'hff, 8'hc0)));
            end
        endcase
        foreach (seq[i]) begin
            add_byte(seq[i], i == seq.size() - 1 ? eos : 1'b0);
        end
    endtask

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(2_000_000);
        $display("utf8_decode_width_classifier_top regression: fail");
        $finish;
    end

    // request driver
    always @(posedge aclk) begin
        byte_req_t req;
        if (!aresetn) begin
            s_valid         <= 1'b0;
            s_data_byte     <= 8'h00;
            s_end_of_stream <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_end_of_stream);
                sent <= sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (byte_q.size() > 0 &&
                    ((sent >= 90 && sent < 140) || $urandom_range(99) >= 14)) begin
                    req = byte_q.pop_front();
                    s_valid         <= 1'b1;
                    s_data_byte     <= req.data;
                    s_end_of_stream <= req.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        glyph_t seen;
        glyph_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (got >= 40 && got < 90) || $urandom_range(99) >= 14;
            if (m_valid && m_ready) begin
                got <= got + 1;
                seen = {m_scalar_value, m_byte_count, m_is_valid, m_is_control,
                        m_display_width, m_is_unsafe, m_last_result};
                if (glyph_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: val=%h cnt=%0d ok=%b", seen.scalar,
                                 seen.count, seen.ok);
                    end
                end else begin
                    want = glyph_q.pop_front();
                    if (seen !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch exp: val=%h cnt=%0d ok=%b ctl=%b w=%0d uns=%b lst=%b",
                                     want.scalar, want.count, want.ok, want.ctrl, want.cols,
                                     want.unsafe, want.last_flag);
                            $display("         got: val=%h cnt=%0d ok=%b ctl=%b w=%0d uns=%b lst=%b",
                                     seen.scalar, seen.count, seen.ok, seen.ctrl, seen.cols,
                                     seen.unsafe, seen.last_flag);
                        end
                    end
                end
            end
        end
    end

    initial begin
        // nul, C1 control, zero-width unsafe, stray continuation, bad lead,
        // overlong, surrogate, above range, broken sequence, flush, max scalar
        add_byte(8'h00, 1'b0);
        add_byte(8'hc2, 1'b0);
        add_byte(8'h80, 1'b0);
        add_scalar(21'h200b, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'hc0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hed, 1'b0);
        add_byte(8'ha0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hf4, 1'b0);
        add_byte(8'h90, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'he2, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hf0, 1'b0);
        add_byte(8'h9f, 1'b1);
        add_scalar(21'h10ffff, 1'b0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // hold off new requests until every pending result has drained
        do @(posedge aclk);
        while (byte_q.size() != 0 || s_valid || glyph_q.size() != 0);
        repeat (4) @(posedge aclk);

        while (queued < 180) begin
            if ($urandom_range(99) < 70) begin
                add_valid();
            end else begin
                add_noise();
            end
        end

        do @(posedge aclk);
        while (byte_q.size() != 0 || s_valid || glyph_q.size() != 0);
        repeat (20) @(posedge aclk);

        if (glyph_q.size() != 0) begin
            errors++;
            $display("missing results: %0d", glyph_q.size());
        end
        if (errors == 0) begin
            $display("utf8_decode_width_classifier_top regression: pass");
        end else begin
            $display("utf8_decode_width_classifier_top regression: fail");
        end
        $finish;
    end

endmodule
